FILE: rtl/core/id_record_validator_assert.svh
// Assertion macros for the identity record validator.
// Every check samples on the rising edge of clk and is held off while arst_n is low.
`ifndef ID_RECORD_VALIDATOR_ASSERT_SVH
`define ID_RECORD_VALIDATOR_ASSERT_SVH

// Check a property on the rising edge of clk. The check is off while in reset.
`define IRV_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Check that a condition holds on every result that is shown on the output.
`define IRV_ASSERT_OUT(label, cond, msg) \
	`IRV_ASSERT(label, out_valid |-> (cond), msg)

`endif

FILE: rtl/core/irv_pkg.sv
package irv_pkg;

	localparam int RECORD_LENGTH = 32;
	localparam int SERIAL_LENGTH = 16;
	localparam int MAX_EMIT      = 16;
	localparam int EMIT_COUNT    = (SERIAL_LENGTH < MAX_EMIT) ? SERIAL_LENGTH : MAX_EMIT;

	localparam int POS_W   = $clog2(RECORD_LENGTH);
	localparam int SIDX_W  = $clog2(EMIT_COUNT);
	localparam int IDX_W   = 4;
	localparam int MASK_W  = 64;

	localparam logic [7:0] MAGIC0   = 8'h5A;
	localparam logic [7:0] MAGIC1   = 8'hC5;
	localparam logic [7:0] CRC_POLY = 8'h07;

	localparam logic [IDX_W-1:0] EMIT_LAST = IDX_W'(EMIT_COUNT - 1);

	typedef enum logic [2:0] {
		ST_OK        = 3'd0,
		ST_BUS_ERR   = 3'd1,
		ST_BAD_MAGIC = 3'd2,
		ST_BAD_CRC   = 3'd3,
		ST_UNSUP_REV = 3'd4
	} status_t;

	// Controller to datapath
	typedef struct packed {
		logic             take;
		logic             emit;
		logic [IDX_W-1:0] idx;
	} irv_cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic report_now;
		logic good_end;
	} irv_sts_t;

	// CRC-8, MSB first, no reflection
	function automatic logic [7:0] crc8_step(input logic [7:0] crc, input logic [7:0] b);
		logic [7:0] v;
		v = crc ^ b;
		for (int k = 0; k < 8; k++) begin
			v = v[7] ? ((v << 1) ^ CRC_POLY) : (v << 1);
		end
		return v;
	endfunction

endpackage

FILE: rtl/core/irv_ctrl.sv
module irv_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	output logic              out_valid,
	input  logic              out_ready,
	input  irv_pkg::irv_sts_t sts,
	output irv_pkg::irv_cmd_t cmd
);
	import irv_pkg::*;

	typedef enum logic {
		S_RUN,
		S_EMIT
	} state_t;

	state_t           state_q;
	logic             out_valid_q;
	logic [IDX_W-1:0] idx_q;
	logic             out_free;

	assign out_free  = !out_valid_q || out_ready;
	assign in_ready  = (state_q == S_RUN) && out_free;
	assign out_valid = out_valid_q;

	assign cmd.take = in_valid && in_ready;
	assign cmd.emit = (state_q == S_EMIT) && out_free;
	assign cmd.idx  = idx_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_RUN;
			out_valid_q <= 1'b0;
			idx_q       <= '0;
		end else begin
			if ((cmd.take && sts.report_now) || cmd.emit) out_valid_q <= 1'b1;
			else if (out_ready)                          out_valid_q <= 1'b0;
			unique case (state_q)
				S_RUN: begin
					if (cmd.take && sts.good_end) begin
						state_q <= S_EMIT;
						idx_q   <= '0;
					end
				end
				S_EMIT: begin
					if (cmd.emit) begin
						idx_q <= idx_q + 1'b1;
						if (idx_q == EMIT_LAST) state_q <= S_RUN;
					end
				end
				default: state_q <= S_RUN;
			endcase
		end
	end

endmodule

FILE: rtl/core/irv_dp.sv
module irv_dp (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_wr_en,
	input  logic [irv_pkg::MASK_W-1:0] cfg_wr_data,
	input  logic [7:0]                data_byte,
	input  logic                      read_error,
	input  irv_pkg::irv_cmd_t         cmd,
	output irv_pkg::irv_sts_t         sts,
	output logic [2:0]                status,
	output logic [7:0]                revision,
	output logic [7:0]                serial_byte,
	output logic [irv_pkg::IDX_W-1:0] serial_index,
	output logic                      last
);
	import irv_pkg::*;

	logic [MASK_W-1:0] mask_q;
	logic [POS_W-1:0]  pos_q;
	logic [7:0]        crc_q;
	logic              magic_q;
	logic [7:0]        rev_seen_q;
	logic [7:0]        store_q [EMIT_COUNT];

	status_t           st_q;
	logic [7:0]        rev_q;
	logic [7:0]        ser_q;
	logic [IDX_W-1:0]  idx_q;
	logic              last_q;

	logic              final_byte;
	logic [POS_W-1:0]  soff;
	logic              in_serial;
	logic              magic_byte_ok;
	logic              rev_ok;
	status_t           chk;

	assign final_byte = (pos_q == POS_W'(RECORD_LENGTH - 1));
	assign soff       = pos_q - POS_W'(3);
	assign in_serial  = (pos_q >= POS_W'(3)) && ({1'b0, soff} < (POS_W + 1)'(EMIT_COUNT));

	always_comb begin
		magic_byte_ok = 1'b1;
		if (pos_q == POS_W'(0) && data_byte != MAGIC0) magic_byte_ok = 1'b0;
		if (pos_q == POS_W'(1) && data_byte != MAGIC1) magic_byte_ok = 1'b0;
	end

	assign rev_ok = (rev_seen_q[7:6] == 2'b00) && mask_q[rev_seen_q[5:0]];

	// Check order: magic, then CRC, then revision
	always_comb begin
		if (!magic_q)                chk = ST_BAD_MAGIC;
		else if (data_byte != crc_q) chk = ST_BAD_CRC;
		else if (!rev_ok)            chk = ST_UNSUP_REV;
		else                         chk = ST_OK;
	end

	assign sts.report_now = read_error || (final_byte && chk != ST_OK);
	assign sts.good_end   = !read_error && final_byte && chk == ST_OK;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mask_q     <= '0;
			pos_q      <= '0;
			crc_q      <= '0;
			magic_q    <= 1'b1;
			rev_seen_q <= '0;
		end else begin
			if (cfg_wr_en) mask_q <= cfg_wr_data;
			if (cmd.take) begin
				if (read_error || final_byte) begin
					pos_q   <= '0;
					crc_q   <= '0;
					magic_q <= 1'b1;
				end else begin
					pos_q   <= pos_q + 1'b1;
					crc_q   <= crc8_step(crc_q, data_byte);
					magic_q <= magic_q && magic_byte_ok;
					if (pos_q == POS_W'(2)) rev_seen_q <= data_byte;
				end
			end
		end
	end

	// Serial store and result register
	always_ff @(posedge clk) begin
		if (cmd.take && !read_error && in_serial) store_q[soff[SIDX_W-1:0]] <= data_byte;
		if (cmd.take && read_error) begin
			st_q   <= ST_BUS_ERR;
			rev_q  <= '0;
			ser_q  <= '0;
			idx_q  <= '0;
			last_q <= 1'b1;
		end else if (cmd.take && final_byte && chk != ST_OK) begin
			st_q   <= chk;
			rev_q  <= '0;
			ser_q  <= '0;
			idx_q  <= '0;
			last_q <= 1'b1;
		end else if (cmd.emit) begin
			st_q   <= ST_OK;
			rev_q  <= rev_seen_q;
			ser_q  <= (cmd.idx == EMIT_LAST) ? 8'h00 : store_q[cmd.idx[SIDX_W-1:0]];
			idx_q  <= cmd.idx;
			last_q <= (cmd.idx == EMIT_LAST);
		end
	end

	assign status       = st_q;
	assign revision     = rev_q;
	assign serial_byte  = ser_q;
	assign serial_index = idx_q;
	assign last         = last_q;

endmodule

FILE: rtl/core/id_record_validator.sv
// Channel   | Handshake            | Payload
// ----------+----------------------+-------------------------------------------
// input     | in_valid / in_ready  | data_byte, read_error
// output    | out_valid / out_ready| status, revision, serial_byte,
//           |                      | serial_index, last
// config    | cfg_wr_en            | cfg_wr_data (supported revision bitmap)
//
// Record bytes are taken at one per cycle while the result register is free.
// After a good final byte, input stalls until all EMIT_COUNT serial bytes (16 by default)
// have left the single result register, one per cycle unless output backpressure holds
// them; errors cost one result and no input stall.
// arst_n clears the controller, record state and bitmap; the serial store is not cleared.
// Downstream stalls hold the result register and drop in_ready.
module id_record_validator (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_wr_en,
	input  logic [irv_pkg::MASK_W-1:0] cfg_wr_data,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  logic [7:0]                 data_byte,
	input  logic                       read_error,
	output logic                       out_valid,
	input  logic                       out_ready,
	output logic [2:0]                 status,
	output logic [7:0]                 revision,
	output logic [7:0]                 serial_byte,
	output logic [irv_pkg::IDX_W-1:0]  serial_index,
	output logic                       last
);
	import irv_pkg::*;

	irv_cmd_t cmd;
	irv_sts_t sts;

	// Sequence the record and the serial emission
	irv_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	// Hold the CRC, magic check, revision, serial store and result register
	irv_dp u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_wr_en    (cfg_wr_en),
		.cfg_wr_data  (cfg_wr_data),
		.data_byte    (data_byte),
		.read_error   (read_error),
		.cmd          (cmd),
		.sts          (sts),
		.status       (status),
		.revision     (revision),
		.serial_byte  (serial_byte),
		.serial_index (serial_index),
		.last         (last)
	);

endmodule

FILE: rtl/core/irv_checker.sv
`include "id_record_validator_assert.svh"

module irv_checker (
	input logic                      clk,
	input logic                      arst_n,
	input logic                      out_valid,
	input logic                      out_ready,
	input logic [2:0]                status,
	input logic [7:0]                revision,
	input logic [7:0]                serial_byte,
	input logic [irv_pkg::IDX_W-1:0] serial_index,
	input logic                      last
);
	import irv_pkg::*;

	`IRV_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid, "output dropped while stalled")
	`IRV_ASSERT_OUT(a_err_last, status == ST_OK || last, "error result without last")
	`IRV_ASSERT_OUT(a_err_zero, status == ST_OK || (revision == 8'h00 && serial_byte == 8'h00 && serial_index == '0), "error result with nonzero fields")
	`IRV_ASSERT_OUT(a_ok_final, status != ST_OK || !last || (serial_byte == 8'h00 && serial_index == EMIT_LAST), "final serial byte not cleared")

endmodule

bind id_record_validator irv_checker u_irv_checker (.*);

FILE: tb/id_record_validator_test.sv
`timescale 1ns / 1ps

module id_record_validator_test;
	import irv_pkg::*;

	// Kinds of record the stimulus can build
	typedef enum int unsigned {
		REC_GOOD,
		REC_BAD_MAGIC,
		REC_BAD_CRC,
		REC_NOISE,
		REC_ABORT
	} record_kind_t;

	// One result item as the block should present it
	typedef struct {
		status_t          status;
		logic [7:0]       revision;
		logic [7:0]       serial_byte;
		logic [IDX_W-1:0] serial_index;
		logic             last;
	} record_result_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_wr_en = 1'b0;
	logic [MASK_W-1:0] cfg_wr_data = '0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic [7:0] data_byte = 8'h00;
	logic read_error = 1'b0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic [2:0] status;
	logic [7:0] revision;
	logic [7:0] serial_byte;
	logic [IDX_W-1:0] serial_index;
	logic last;

	// Results the block still owes us, oldest first
	record_result_t awaited_results[$];
	int fail_count = 0;

	// Own copy of the block's record state and revision bitmap
	int rec_pos = 0;
	logic [7:0] rec_crc = 8'h00;
	logic rec_magic_ok = 1'b1;
	logic [7:0] rec_revision = 8'h00;
	logic [7:0] rec_serial [SERIAL_LENGTH];
	logic [MASK_W-1:0] revision_mask = '0;

	// When set, the matching side runs with no idle cycles
	bit tx_calm = 1'b0;
	bit rx_calm = 1'b0;
	int rx_hold = 0;

	id_record_validator DUT (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_wr_en(cfg_wr_en),
		.cfg_wr_data(cfg_wr_data),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.data_byte(data_byte),
		.read_error(read_error),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.status(status),
		.revision(revision),
		.serial_byte(serial_byte),
		.serial_index(serial_index),
		.last(last)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// CRC-8, polynomial x^8+x^2+x+1, shifted in MSB first one bit at a time
	function automatic logic [7:0] crc8_update(input logic [7:0] crc, input logic [7:0] b);
		logic [7:0] c;
		logic fb;
		int i;
		c = crc;
		for (i = 7; i >= 0; i--) begin
			fb = c[7] ^ b[i];
			c = {c[6:0], 1'b0} ^ (fb ? 8'h07 : 8'h00);
		end
		return c;
	endfunction

	function automatic void clear_record_state();
		rec_pos = 0;
		rec_crc = 8'h00;
		rec_magic_ok = 1'b1;
		rec_revision = 8'h00;
	endfunction

	function automatic void push_result(input status_t st, input logic [7:0] rev,
			input logic [7:0] sb, input logic [IDX_W-1:0] idx, input logic fin);
		record_result_t r;
		r.status = st;
		r.revision = rev;
		r.serial_byte = sb;
		r.serial_index = idx;
		r.last = fin;
		awaited_results.push_back(r);
	endfunction

	// Advance the record state by one accepted item and queue what it causes
	function automatic void absorb_record_byte(input logic [7:0] d, input logic err);
		status_t verdict;
		int k;
		if (err) begin
			// read failure: drop the record, report a bus error
			clear_record_state();
			push_result(ST_BUS_ERR, 8'h00, 8'h00, '0, 1'b1);
			return;
		end
		if (rec_pos == 0 && d != MAGIC0)
			rec_magic_ok = 1'b0;
		if (rec_pos == 1 && d != MAGIC1)
			rec_magic_ok = 1'b0;
		if (rec_pos == 2)
			rec_revision = d;
		if (rec_pos >= 3 && rec_pos - 3 < SERIAL_LENGTH)
			rec_serial[rec_pos - 3] = d;
		if (rec_pos + 1 < RECORD_LENGTH) begin
			rec_crc = crc8_update(rec_crc, d);
			rec_pos++;
			return;
		end
		// final byte: magic first, then CRC, then revision support
		if (!rec_magic_ok)
			verdict = ST_BAD_MAGIC;
		else if (d != rec_crc)
			verdict = ST_BAD_CRC;
		else if (rec_revision >= 8'd64 || !revision_mask[rec_revision[5:0]])
			verdict = ST_UNSUP_REV;
		else
			verdict = ST_OK;
		if (verdict != ST_OK) begin
			push_result(verdict, 8'h00, 8'h00, '0, 1'b1);
		end else begin
			// the final serial character always comes out as zero
			for (k = 0; k < EMIT_COUNT; k++) begin
				if (k == EMIT_COUNT - 1)
					push_result(ST_OK, rec_revision, 8'h00, IDX_W'(k), 1'b1);
				else
					push_result(ST_OK, rec_revision, rec_serial[k], IDX_W'(k), 1'b0);
			end
		end
		clear_record_state();
	endfunction

	task automatic flag_field(input string name, input int want, input int got);
		$display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
		fail_count++;
	endtask

	// Result side: check every accepted item, then draw the stall before the next one
	always @(posedge clk) begin : take_result
		record_result_t want;
		int w;
		if (arst_n) begin
			if (out_valid && out_ready) begin
				if (awaited_results.size() == 0) begin
					$display("%0t: unexpected result, status %0d revision %0d serial %0d index %0d last %0d",
						$time, status, revision, serial_byte, serial_index, last);
					fail_count++;
				end else begin
					want = awaited_results.pop_front();
					if (status != want.status)
						flag_field("status", want.status, status);
					if (revision != want.revision)
						flag_field("revision", want.revision, revision);
					if (serial_byte != want.serial_byte)
						flag_field("serial_byte", want.serial_byte, serial_byte);
					if (serial_index != want.serial_index)
						flag_field("serial_index", want.serial_index, serial_index);
					if (last != want.last)
						flag_field("last", want.last, last);
				end
				w = rx_calm ? 0 : $urandom_range(0, 14);
				if (w != 0) begin
					out_ready <= 1'b0;
					rx_hold <= w - 1;
				end
			end else if (!out_ready) begin
				if (rx_hold == 0)
					out_ready <= 1'b1;
				else
					rx_hold <= rx_hold - 1;
			end
		end
	end

	// Offer one item after a random gap and hold it until the block takes it
	task automatic send_byte(input logic [7:0] d, input logic err);
		int gap;
		gap = tx_calm ? 0 : $urandom_range(0, 14);
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		data_byte <= d;
		read_error <= err;
		do @(posedge clk); while (!in_ready);
		absorb_record_byte(d, err);
	endtask

	// Drop valid and wait until every queued result has come back
	task automatic wait_for_results();
		in_valid <= 1'b0;
		do @(posedge clk); while (awaited_results.size() != 0);
	endtask

	// Bitmap writes only happen with the block idle
	task automatic load_revision_mask(input logic [MASK_W-1:0] m);
		wait_for_results();
		repeat (4) @(posedge clk);
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= m;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		revision_mask = m;
	endtask

	// Build one record image of the given kind and push it through
	task automatic send_record(input record_kind_t kind, input logic [7:0] rev);
		logic [7:0] img [RECORD_LENGTH];
		logic [7:0] crc;
		int i;
		int cut;
		img[0] = MAGIC0;
		img[1] = MAGIC1;
		img[2] = rev;
		for (i = 3; i < RECORD_LENGTH; i++)
			img[i] = 8'($urandom_range(0, 255));
		if (kind == REC_NOISE) begin
			img[0] = 8'($urandom_range(0, 255));
			img[1] = 8'($urandom_range(0, 255));
			img[2] = 8'($urandom_range(0, 255));
		end
		if (kind == REC_BAD_MAGIC)
			img[$urandom_range(0, 1)] ^= 8'($urandom_range(1, 255));
		crc = 8'h00;
		for (i = 0; i < RECORD_LENGTH - 1; i++)
			crc = crc8_update(crc, img[i]);
		if (kind != REC_NOISE)
			img[RECORD_LENGTH - 1] = crc;
		if (kind == REC_BAD_CRC)
			img[RECORD_LENGTH - 1] ^= 8'($urandom_range(1, 255));
		cut = (kind == REC_ABORT) ? $urandom_range(0, RECORD_LENGTH - 1) : RECORD_LENGTH;
		for (i = 0; i < cut; i++)
			send_byte(img[i], 1'b0);
		if (kind == REC_ABORT)
			send_byte(8'($urandom_range(0, 255)), 1'b1);
	endtask

	// Mostly a supported revision, sometimes any low one, sometimes one past the bitmap
	function automatic logic [7:0] pick_revision();
		int start;
		int t;
		int r;
		if ($urandom_range(0, 7) == 0)
			return 8'($urandom_range(64, 255));
		start = $urandom_range(0, 63);
		if ($urandom_range(0, 7) == 0)
			return 8'(start);
		for (t = 0; t < 64; t++) begin
			r = (start + t) % 64;
			if (revision_mask[r])
				return 8'(r);
		end
		return 8'(start);
	endfunction

	task automatic draw_idle_modes();
		tx_calm = ($urandom_range(0, 3) == 0);
		rx_calm = ($urandom_range(0, 3) == 0);
	endtask

	// Read errors at the first byte and in the middle of a record; data is ignored
	task automatic test_read_error();
		load_revision_mask('0);
		draw_idle_modes();
		send_byte(8'hFF, 1'b1);
		send_byte(MAGIC0, 1'b0);
		send_byte(MAGIC1, 1'b0);
		send_byte(8'h07, 1'b0);
		send_byte(8'h00, 1'b1);
		// a lone revision 0 with an empty bitmap is unsupported
		send_record(REC_GOOD, 8'h00);
	endtask

	// All bitmap bits set; the top supported revision passes and streams serial bytes, and 255 is unsupported
	task automatic test_good_record();
		load_revision_mask('1);
		draw_idle_modes();
		send_record(REC_GOOD, 8'd63);
		send_record(REC_GOOD, 8'd255);
	endtask

	// Random records under several bitmaps, including both extremes
	task automatic test_random_records();
		logic [MASK_W-1:0] m;
		int phase;
		int n;
		int pick;
		record_kind_t kind;
		for (phase = 0; phase < 5; phase++) begin
			case (phase)
				0: m = '1;
				1: m = 64'h1 << $urandom_range(0, 63);
				2: m = {$urandom, $urandom};
				3: m = 64'h8000_0000_0000_0001;
				default: m = '0;
			endcase
			load_revision_mask(m);
			for (n = 0; n < 3; n++) begin
				draw_idle_modes();
				pick = $urandom_range(0, 19);
				if (pick < 9)
					kind = REC_GOOD;
				else if (pick < 11)
					kind = REC_BAD_MAGIC;
				else if (pick < 14)
					kind = REC_BAD_CRC;
				else if (pick < 16)
					kind = REC_NOISE;
				else
					kind = REC_ABORT;
				send_record(kind, pick_revision());
				// hold off now and then until the serial stream has fully drained
				if (kind == REC_GOOD && $urandom_range(0, 2) == 0)
					wait_for_results();
			end
		end
	endtask

	initial begin
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_read_error();
		test_good_record();
		test_random_records();
		wait_for_results();
		repeat (20) @(posedge clk);
		if (fail_count == 0 && awaited_results.size() == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

	initial begin
		#2000000;
		$display("Test completed with failures");
		$finish;
	end

endmodule
